### sv/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define SRL_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define SRL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### sv/srl_pkg.sv
`default_nettype none
package srl_pkg;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_TYPE  = 3'd1,
		PH_COUNT = 3'd2,
		PH_ADDR  = 3'd3,
		PH_DATA  = 3'd4,
		PH_CHECK = 3'd5,
		PH_SKIP  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		KIND_WRITE    = 2'd0,
		KIND_DONE     = 2'd1,
		KIND_CSUM_ERR = 2'd2,
		KIND_SKIPPED  = 2'd3
	} kind_t;

	localparam logic [3:0] RK_UNKNOWN = 4'd15;

	localparam logic [7:0] CH_0  = 8'h30;
	localparam logic [7:0] CH_9  = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [7:0] CH_US = 8'h53;
	localparam logic [7:0] CH_LS = 8'h73;
	localparam logic [7:0] HEX_TEN = 8'd10;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] addr;
		logic [7:0]  data;
		logic [7:0]  expct;
		logic [7:0]  type_char;
	} res_t;

	// non-hex characters keep their raw code
	function automatic logic [7:0] nibble_of(input logic [7:0] c);
		logic [7:0] v;
		v = c;
		if (c >= CH_0 && c <= CH_9)
			v = c - CH_0;
		else if (c >= CH_UA && c <= CH_UF)
			v = c - CH_UA + HEX_TEN;
		else if (c >= CH_LA && c <= CH_LF)
			v = c - CH_LA + HEX_TEN;
		return v;
	endfunction

endpackage
`default_nettype wire

### sv/srl_in_stage.sv
`default_nettype none
module srl_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] ch,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      ch_s1
);
	import srl_pkg::*;

	logic accept;

	// holds one character while the result side is stalled
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1 <= ch;
		end
	end

endmodule
`default_nettype wire

### sv/srl_parse.sv
`default_nettype none
module srl_parse (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [31:0] cfg_data,
	input  wire logic        fire,
	input  wire logic [7:0]  ch_s1,
	output logic             res_valid,
	output srl_pkg::res_t    res
);
	import srl_pkg::*;

	phase_t      phase_q, phase_n;
	logic [3:0]  rk_q, rk_n;
	logic [7:0]  pairs_q, pairs_n;
	logic [2:0]  abl_q, abl_n;
	logic [31:0] load_q, load_n;
	logic [7:0]  sum_q, sum_n;
	logic [7:0]  first_q, first_n;
	logic        second_q, second_n;
	logic [7:0]  held_q, held_n;
	logic [31:0] offset_q;

	logic [7:0]  hi_nib;
	logic [7:0]  lo_nib;
	logic [7:0]  byte_val;
	logic [7:0]  pl_dec;
	logic [2:0]  abl_dec;
	logic [31:0] la_shift;
	logic        is_data;
	logic        is_end;

	assign hi_nib   = nibble_of(first_q);
	assign lo_nib   = nibble_of(ch_s1);
	assign byte_val = {hi_nib[3:0], 4'b0000} | lo_nib;
	assign pl_dec   = (pairs_q == 8'd0) ? 8'd0 : pairs_q - 8'd1;
	assign abl_dec  = (abl_q == 3'd0) ? 3'd0 : abl_q - 3'd1;
	assign la_shift = {load_q[23:0], byte_val};
	assign is_data  = (rk_q >= 4'd1) && (rk_q <= 4'd3);
	assign is_end   = (rk_q >= 4'd7) && (rk_q <= 4'd9);

	always_comb begin
		phase_n   = phase_q;
		rk_n      = rk_q;
		pairs_n   = pairs_q;
		abl_n     = abl_q;
		load_n    = load_q;
		sum_n     = sum_q;
		first_n   = first_q;
		second_n  = second_q;
		held_n    = held_q;
		res_valid = 1'b0;
		res.kind      = KIND_WRITE;
		res.addr      = 32'd0;
		res.data      = 8'd0;
		res.expct     = 8'd0;
		res.type_char = held_q;
		if (fire) begin
			unique case (phase_q)
				PH_TYPE: begin
					held_n = ch_s1;
					if (ch_s1 >= CH_0 && ch_s1 <= CH_9)
						rk_n = 4'(ch_s1 - CH_0);
					else
						rk_n = RK_UNKNOWN;
					phase_n  = PH_COUNT;
					second_n = 1'b0;
				end
				PH_COUNT, PH_ADDR, PH_DATA, PH_CHECK, PH_SKIP: begin
					if (!second_q) begin
						first_n  = ch_s1;
						second_n = 1'b1;
					end else begin
						second_n = 1'b0;
						unique case (phase_q)
							PH_COUNT: begin
								pairs_n = byte_val;
								sum_n   = byte_val;
								load_n  = 32'd0;
								if (rk_q == 4'd0) begin
									phase_n = PH_SKIP;
								end else if (is_data) begin
									abl_n   = 3'(rk_q + 4'd1);
									phase_n = PH_ADDR;
								end else if (is_end) begin
									abl_n   = 3'(4'd11 - rk_q);
									phase_n = PH_ADDR;
								end else begin
									phase_n   = PH_HUNT;
									res_valid = 1'b1;
									res.kind  = KIND_SKIPPED;
								end
							end
							PH_ADDR: begin
								sum_n = sum_q + byte_val;
								abl_n = abl_dec;
								if (abl_dec == 3'd0) begin
									load_n = la_shift + offset_q;
									if (pl_dec > 8'd1) begin
										pairs_n = pl_dec - 8'd1;
										phase_n = PH_DATA;
									end else begin
										pairs_n = 8'd0;
										phase_n = PH_CHECK;
									end
								end else begin
									load_n  = la_shift;
									pairs_n = pl_dec;
								end
							end
							PH_DATA: begin
								sum_n   = sum_q + byte_val;
								pairs_n = pl_dec;
								if (pl_dec == 8'd0)
									phase_n = PH_CHECK;
								if (is_data) begin
									load_n    = load_q + 32'd1;
									res_valid = 1'b1;
									res.kind  = KIND_WRITE;
									res.addr  = load_q;
									res.data  = byte_val;
								end
							end
							PH_CHECK: begin
								phase_n = PH_HUNT;
								if (byte_val != ~sum_q) begin
									res_valid = 1'b1;
									res.kind  = KIND_CSUM_ERR;
									res.addr  = load_q;
									res.data  = byte_val;
									res.expct = ~sum_q;
								end else if (is_end) begin
									res_valid = 1'b1;
									res.kind  = KIND_DONE;
									res.addr  = load_q;
								end
							end
							default: begin
								// type 0 skip: count + 1 pairs after the count
								if (pairs_q == 8'd0)
									phase_n = PH_HUNT;
								else
									pairs_n = pl_dec;
							end
						endcase
					end
				end
				default: begin
					// hunting, and the unused phase code
					phase_n = PH_HUNT;
					if (ch_s1 == CH_US || ch_s1 == CH_LS)
						phase_n = PH_TYPE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			rk_q     <= 4'd0;
			pairs_q  <= 8'd0;
			abl_q    <= 3'd0;
			load_q   <= 32'd0;
			sum_q    <= 8'd0;
			first_q  <= 8'd0;
			second_q <= 1'b0;
			held_q   <= 8'd0;
			offset_q <= 32'd0;
		end else begin
			phase_q  <= phase_n;
			rk_q     <= rk_n;
			pairs_q  <= pairs_n;
			abl_q    <= abl_n;
			load_q   <= load_n;
			sum_q    <= sum_n;
			first_q  <= first_n;
			second_q <= second_n;
			held_q   <= held_n;
			if (cfg_write) begin
				offset_q <= cfg_data;
			end
		end
	end

endmodule
`default_nettype wire

### sv/srl_out_stage.sv
`default_nettype none
module srl_out_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          res_valid,
	input  wire srl_pkg::res_t res,
	output logic               advance,
	output logic               out_valid,
	input  wire logic          out_stall,
	output srl_pkg::res_t      out_q
);
	import srl_pkg::*;

	// the register frees up when empty or when its transfer completes
	assign advance = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

### sv/srecord_stream_loader_core.sv
// S-record stream loader.
// Input channel: one host character per transfer on ch (in_valid / in_stall).
// Output channel: one result per transfer: kind, write_address, write_data,
// expected_checksum, type_char (out_valid / out_stall). Kind 0 is a memory
// write, 1 the end record was good, 2 a checksum error, 3 an unknown record.
// Most characters produce no result; a data byte's second hex character
// produces a write.
// cfg_write / cfg_data load the 32-bit address offset; write it while idle.
// A character that causes a result is captured in the input register; the parser
// then decodes it and the result register takes the result once it can advance.
// Throughput: one character per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds and the input register
// takes at most one more character, then in_stall rises until the result moves.
// Reset (arst_n low) empties both registers, clears the offset and puts the
// parser back to hunting for 'S' or 's'.
`default_nettype none
module srecord_stream_loader_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  ch,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [31:0]      write_address,
	output logic [7:0]       write_data,
	output logic [7:0]       expected_checksum,
	output logic [7:0]       type_char
);
	import srl_pkg::*;
	`include "assert_macros.svh"

	logic       advance;
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       fire;
	logic       res_valid;
	res_t       res;
	res_t       out_q;

	assign fire = valid_s1 && advance;

	srl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.ch_s1    (ch_s1)
	);

	srl_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.ch_s1     (ch_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	srl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_q     (out_q)
	);

	assign kind              = out_q.kind;
	assign write_address     = out_q.addr;
	assign write_data        = out_q.data;
	assign expected_checksum = out_q.expct;
	assign type_char         = out_q.type_char;

	`SRL_ASSERT_IMP(a_res_needs_fire, clk, arst_n, res_valid, fire, "result without a character")
	`SRL_ASSERT_IMP(a_stall_needs_s1, clk, arst_n, in_stall, valid_s1 && out_valid && out_stall, "input stalled without a held character")
	`SRL_ASSERT_IMP(a_write_fields, clk, arst_n, out_valid && kind == KIND_WRITE, expected_checksum == 8'd0, "write carries a checksum")
	`SRL_ASSERT_IMP(a_skip_fields, clk, arst_n, out_valid && kind == KIND_SKIPPED, write_address == 32'd0 && write_data == 8'd0, "unknown record report carries data")

endmodule
`default_nettype wire
